// ----- rtl/ipv4_udp_redirect_classifier_unit_macros.svh -----
// Assertion macros for the IPv4/UDP redirect classifier.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef IPV4_UDP_REDIRECT_CLASSIFIER_UNIT_MACROS_SVH
`define IPV4_UDP_REDIRECT_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IRC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/irc_pkg.sv -----
// Shared types and constants for the IPv4/UDP redirect classifier.
// No dependencies; imported by every module of the block.
package irc_pkg;

    // Frame layout and protocol constants
    localparam logic [8:0] ETH_HDR_LEN  = 9'd14;
    localparam logic [8:0] IP_MIN_LEN   = 9'd34;
    localparam logic [8:0] UDP_HDR_LEN  = 9'd8;
    localparam logic [3:0] IP_MIN_WORDS = 4'd5;
    localparam logic [3:0] IP_VERSION   = 4'd4;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] ETYPE_HI     = 8'h08;
    localparam logic [7:0] ETYPE_LO     = 8'h00;

    // Byte positions inside the frame
    localparam logic [7:0] POS_ETYPE_HI = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO = 8'd13;
    localparam logic [7:0] POS_VER_LEN  = 8'd14;
    localparam logic [7:0] POS_PROTOCOL = 8'd23;
    localparam logic [7:0] POS_DADDR_LO = 8'd30;
    localparam logic [7:0] POS_DADDR_HI = 8'd33;
    localparam logic [7:0] POS_MAX      = 8'd255;

    // Number of receive queues that may be redirected to
    localparam int QUEUE_COUNT = 64;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DEST_ADDR = 2'd0;
    localparam logic [1:0] REG_DEST_PORT = 2'd1;
    localparam logic [1:0] REG_PROTOCOL  = 2'd2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
    } t_match_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
        logic [5:0] rx_queue;
    } t_byte_item;

    typedef struct packed {
        logic       verdict;
        logic [5:0] target_queue;
    } t_verdict;

endpackage

// ----- rtl/irc_cfg_regs.sv -----
// Match setting registers behind the APB-style configuration port.
// Depends on irc_pkg.
module irc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [irc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [irc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [irc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output irc_pkg::t_match_cfg              o_cfg
);
    import irc_pkg::*;

    t_match_cfg  r_cfg;
    t_match_cfg  n_cfg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Decode the write transaction
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DEST_ADDR: n_cfg.dest_addr = pwdata[31:0];
                REG_DEST_PORT: n_cfg.dest_port = pwdata[15:0];
                REG_PROTOCOL:  n_cfg.protocol  = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_DEST_ADDR: prdata = r_cfg.dest_addr;
            REG_DEST_PORT: prdata = {16'd0, r_cfg.dest_port};
            REG_PROTOCOL:  prdata = {24'd0, r_cfg.protocol};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/irc_frame_parser.sv -----
// Per-frame header tracking and verdict logic of the redirect classifier.
// Depends on irc_pkg.
module irc_frame_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  irc_pkg::t_byte_item  i_item,
    input  irc_pkg::t_match_cfg  i_cfg,
    output irc_pkg::t_verdict    o_verdict
);
    import irc_pkg::*;

    logic [7:0]  r_pos;
    logic        r_eth_ok;
    logic [7:0]  r_ver_len;
    logic [7:0]  r_proto;
    logic [31:0] r_daddr;
    logic [15:0] r_dport;

    logic [7:0]  n_pos;
    logic        n_eth_ok;
    logic [7:0]  n_ver_len;
    logic [7:0]  n_proto;
    logic [31:0] n_daddr;
    logic [15:0] n_dport;

    logic [7:0]  b;
    logic [7:0]  port_at;
    logic [8:0]  len;
    logic [5:0]  hdr_len;
    logic [8:0]  ip_end;
    logic        cfg_zero;
    logic        ip_ok;
    logic        udp_ok;
    logic        redirect;

    assign b       = i_item.data_byte;
    assign port_at = 8'(POS_VER_LEN) + {2'b00, r_ver_len[3:0], 2'b00} + 8'd2;

    // Fold the current byte into the header fields
    always_comb begin
        n_eth_ok  = r_eth_ok;
        n_ver_len = r_ver_len;
        n_proto   = r_proto;
        n_daddr   = r_daddr;
        n_dport   = r_dport;
        priority if (r_pos == POS_ETYPE_HI) begin
            n_eth_ok = (b == ETYPE_HI);
        end else if (r_pos == POS_ETYPE_LO) begin
            n_eth_ok = r_eth_ok & (b == ETYPE_LO);
        end else if (r_pos == POS_VER_LEN) begin
            n_ver_len = b;
        end else if (r_pos == POS_PROTOCOL) begin
            n_proto = b;
        end else if (r_pos >= POS_DADDR_LO && r_pos <= POS_DADDR_HI) begin
            n_daddr = {r_daddr[23:0], b};
        end
        if (r_pos > POS_VER_LEN && (r_pos == port_at || r_pos == port_at + 8'd1)) begin
            n_dport = {r_dport[7:0], b};
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 8'd1;
    end

    // Decide on the header as it stands after the current byte
    assign len      = {1'b0, r_pos} + 9'd1;
    assign hdr_len  = {n_ver_len[3:0], 2'b00};
    assign ip_end   = ETH_HDR_LEN + {3'b000, hdr_len};
    assign cfg_zero = (i_cfg.dest_addr == '0) && (i_cfg.dest_port == '0)
                    && (i_cfg.protocol == '0);

    assign ip_ok = (len >= IP_MIN_LEN)
                && (n_ver_len[7:4] == IP_VERSION)
                && (n_ver_len[3:0] >= IP_MIN_WORDS)
                && (len >= ip_end)
                && ((i_cfg.dest_addr == '0) || (n_daddr == i_cfg.dest_addr))
                && (n_proto == i_cfg.protocol);

    assign udp_ok = (i_cfg.protocol != PROTO_UDP)
                 || ((i_cfg.dest_port != '0)
                     && (len >= ip_end + UDP_HDR_LEN)
                     && (n_dport == i_cfg.dest_port));

    assign redirect = (len >= ETH_HDR_LEN) && n_eth_ok
                   && (cfg_zero || ((i_cfg.protocol != '0) && ip_ok && udp_ok))
                   && ({3'b000, i_item.rx_queue} < 9'(QUEUE_COUNT));

    assign o_verdict.verdict      = redirect;
    assign o_verdict.target_queue = redirect ? i_item.rx_queue : 6'd0;

    // Advance the frame state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_eth_ok  <= 1'b0;
            r_ver_len <= '0;
            r_proto   <= '0;
            r_daddr   <= '0;
            r_dport   <= '0;
        end else if (i_fire) begin
            if (i_item.end_of_frame) begin
                r_pos     <= '0;
                r_eth_ok  <= 1'b0;
                r_ver_len <= '0;
                r_proto   <= '0;
                r_daddr   <= '0;
                r_dport   <= '0;
            end else begin
                r_pos     <= n_pos;
                r_eth_ok  <= n_eth_ok;
                r_ver_len <= n_ver_len;
                r_proto   <= n_proto;
                r_daddr   <= n_daddr;
                r_dport   <= n_dport;
            end
        end
    end

endmodule

// ----- rtl/ipv4_udp_redirect_classifier_unit.sv -----
// IPv4/UDP redirect classifier: top level with input and result registers.
// Depends on irc_pkg, irc_cfg_regs, irc_frame_parser and the macros header.
//
// Usage:
//   The slave stream carries an Ethernet frame one byte per transaction,
//   starting at the destination MAC address; tlast marks the final byte and
//   tuser carries the receive queue. On the final byte the master stream
//   gives one verdict transaction: tuser is 1 to redirect, 0 to pass, and
//   tdata holds the target queue (zero on pass). Other bytes give nothing.
//   Match settings are written over the APB-style port while idle.
// Timing:
//   One byte per cycle sustained, except that a final byte waits while the
//   result register is full and not being taken. A final byte is held in the
//   input register and its verdict is then loaded into the result register,
//   which drives o_m_axis_tvalid until the verdict is taken.
// Reset:
//   Synchronous, active low; clears the valid flags of both registers, the
//   frame state and all match settings.
// Stall:
//   While the receiver holds tready low the verdict waits in the result
//   register; non-final bytes keep flowing, and a final byte waits in the
//   input register until the result register frees up.
module ipv4_udp_redirect_classifier_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Byte stream in
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // end_of_frame
    input  logic [5:0]                       i_s_axis_tuser,  // [5:0] rx_queue
    // Verdict stream out
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata,  // [5:0] target_queue
    output logic                             o_m_axis_tuser,  // verdict
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [irc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [irc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [irc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import irc_pkg::*;

`include "ipv4_udp_redirect_classifier_unit_macros.svh"

    t_match_cfg  cfg;
    t_byte_item  r_in;
    logic        r_in_valid;
    t_verdict    r_out;
    logic        r_out_valid;
    t_verdict    verdict;
    logic        out_free;
    logic        fire;

    irc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Process the held byte unless it is final and the result register is full and not being taken
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && (!r_in.end_of_frame || out_free);
    assign o_s_axis_tready = !r_in_valid || fire;

    irc_frame_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_verdict (verdict)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.data_byte    <= i_s_axis_tdata;
            r_in.end_of_frame <= i_s_axis_tlast;
            r_in.rx_queue     <= i_s_axis_tuser;
        end
    end

    // Result register: load on a final byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in.end_of_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in.end_of_frame) begin
            r_out <= verdict;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.target_queue};
    assign o_m_axis_tuser  = r_out.verdict;

    // Checks on the block's own control
    `IRC_ASSERT_IMPLIES(a_pass_zero_queue, o_m_axis_tvalid && !o_m_axis_tuser,
        o_m_axis_tdata == 8'd0, "pass verdict carries a nonzero queue")
    `IRC_ASSERT_NEXT(a_final_gives_result, fire && r_in.end_of_frame,
        r_out_valid, "final byte processed without a verdict")
    `IRC_ASSERT_NEXT(a_held_byte_kept, r_in_valid && !fire,
        r_in_valid && $stable(r_in), "held byte lost before processing")

endmodule
